[hw/rtl/mpwm_pkg.sv]
// Shared types and constants for the multichannel PWM register block.
package mpwm_pkg;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] ADDR_MODE     = 8'd0;
   localparam logic [7:0] ADDR_CH_BASE  = 8'd6;
   localparam logic [7:0] ADDR_PRESCALE = 8'd254;

   localparam int BIT_RESTART = 7;
   localparam int BIT_SLEEP   = 4;

   localparam logic [7:0] PRESCALE_MIN   = 8'd3;
   localparam logic [7:0] PRESCALE_RESET = 8'd30;
   localparam logic [7:0] MODE_RESET     = 8'h10;

   localparam int CHANNEL_FIELD_BITS = 4;
   localparam int LEVEL_BITS         = 16;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]            read_data;
      logic [LEVEL_BITS-1:0] pwm_levels;
      logic                  period_wrap;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP         = 3'd0,
      OP_TICK        = 3'd1,
      OP_WR_MODE     = 3'd2,
      OP_WR_PRESCALE = 3'd3,
      OP_WR_CHAN     = 3'd4,
      OP_RD_MODE     = 3'd5,
      OP_RD_PRESCALE = 3'd6,
      OP_RD_CHAN     = 3'd7
   } op_kind_type;

   typedef struct packed {
      op_kind_type                   kind;
      logic [CHANNEL_FIELD_BITS-1:0] channel;
      logic                          sel_off;
      logic                          sel_high;
      logic [7:0]                    data;
   } op_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
   } op_slot_type;

endpackage

[hw/rtl/multichannel_pwm_register_block.sv]
// Top level of the multichannel PWM register block.
// Request channel: req_push / req_full carry one transfer per item (tick, byte write or
// byte read) in req_payload; a transfer takes place when req_push is high and req_full low.
// Response channel: rsp_empty / rsp_pop; every request yields exactly one response
// holding read_data, the channel levels after the item and the period wrap flag.
// A decode stage feeds a two-entry operation queue; the execute stage takes one
// operation per cycle, while the result register is empty or being popped, into a single result register.
// A request passes through the queue and then the result register on its way to rsp_payload.
// Throughput: one item per cycle while rsp_pop keeps the result register free; the queue
// keeps accepting while a result waits to be popped.
// Stall: while rsp_pop is low the result holds, the queue fills and req_full rises
// after two more items.
// Reset (synchronous, active high): mode byte 0x10 (asleep), prescale 30, all on/off
// times zero, divider and period counters zero, queue and result register empty.
module multichannel_pwm_register_block #(
   parameter int CHANNEL_COUNT = 16,
   parameter int COUNTER_BITS  = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mpwm_pkg::req_type req_payload,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mpwm_pkg::rsp_type rsp_payload
);

   logic                  queue_full;
   logic                  queue_push;
   mpwm_pkg::op_type      queue_op;
   logic                  queue_pop;
   mpwm_pkg::op_slot_type queue_head;

   mpwm_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_front (
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_op    (queue_op)
   );

   mpwm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (queue_push),
      .push_op (queue_op),
      .full    (queue_full),
      .pop     (queue_pop),
      .head    (queue_head)
   );

   mpwm_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (queue_head),
      .pop         (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/mpwm_front.sv]
// Front end: accept request transfers and decode them into register operations.
module mpwm_front #(
   parameter int CHANNEL_COUNT = 16
) (
   input  logic                  req_push,
   output logic                  req_full,
   input  mpwm_pkg::req_type     req_payload,
   input  logic                  queue_full,
   output logic                  queue_push,
   output mpwm_pkg::op_type      queue_op
);

   logic [7:0] rel_addr;
   logic [5:0] rel_chan;
   logic       chan_hit;

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;

   assign rel_addr = req_payload.reg_addr - mpwm_pkg::ADDR_CH_BASE;
   assign rel_chan = rel_addr[7:2];
   assign chan_hit = (req_payload.reg_addr >= mpwm_pkg::ADDR_CH_BASE)
                     && (rel_chan < 6'(CHANNEL_COUNT));

   always_comb begin
      queue_op.channel  = rel_chan[mpwm_pkg::CHANNEL_FIELD_BITS-1:0];
      queue_op.sel_off  = rel_addr[1];
      queue_op.sel_high = rel_addr[0];
      queue_op.data     = req_payload.write_data;
      queue_op.kind     = mpwm_pkg::OP_NOP;
      case (req_payload.cmd)
         mpwm_pkg::CMD_TICK: begin
            queue_op.kind = mpwm_pkg::OP_TICK;
         end
         mpwm_pkg::CMD_WRITE: begin
            if (req_payload.reg_addr == mpwm_pkg::ADDR_MODE) begin
               queue_op.kind = mpwm_pkg::OP_WR_MODE;
            end else if (req_payload.reg_addr == mpwm_pkg::ADDR_PRESCALE) begin
               queue_op.kind = mpwm_pkg::OP_WR_PRESCALE;
            end else if (chan_hit) begin
               queue_op.kind = mpwm_pkg::OP_WR_CHAN;
            end
         end
         mpwm_pkg::CMD_READ: begin
            if (req_payload.reg_addr == mpwm_pkg::ADDR_MODE) begin
               queue_op.kind = mpwm_pkg::OP_RD_MODE;
            end else if (req_payload.reg_addr == mpwm_pkg::ADDR_PRESCALE) begin
               queue_op.kind = mpwm_pkg::OP_RD_PRESCALE;
            end else if (chan_hit) begin
               queue_op.kind = mpwm_pkg::OP_RD_CHAN;
            end
         end
         default: begin
            queue_op.kind = mpwm_pkg::OP_NOP;
         end
      endcase
   end

endmodule

[hw/rtl/mpwm_queue.sv]
// Two-entry operation queue between the decode front end and the execute back end.
module mpwm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mpwm_pkg::op_type      push_op,
   output logic                  full,
   input  logic                  pop,
   output mpwm_pkg::op_slot_type head
);

   mpwm_pkg::op_type slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign full       = count_ff == 2'd2;
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != 2'd0);
   assign head.valid = count_ff != 2'd0;
   assign head.op    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[hw/rtl/mpwm_back.sv]
// Back end: register file, divider and period counter, channel compare and result register.
module mpwm_back #(
   parameter int CHANNEL_COUNT = 16,
   parameter int COUNTER_BITS  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpwm_pkg::op_slot_type head,
   output logic                  pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output mpwm_pkg::rsp_type     rsp_payload
);

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic [7:0]              mode_ff, mode_in;
   logic [7:0]              prescale_ff, prescale_in;
   logic [7:0]              div_ff, div_in;
   logic [COUNTER_BITS-1:0] period_ff, period_in;
   logic [COUNTER_BITS-1:0] on_ff [CHANNEL_COUNT];
   logic [COUNTER_BITS-1:0] on_in [CHANNEL_COUNT];
   logic [COUNTER_BITS-1:0] off_ff [CHANNEL_COUNT];
   logic [COUNTER_BITS-1:0] off_in [CHANNEL_COUNT];
   logic                    out_valid_ff, out_valid_in;
   mpwm_pkg::rsp_type       out_ff, out_in;

   logic                    load;
   mpwm_pkg::op_type        op;
   logic [CH_W-1:0]         sel;
   logic [COUNTER_BITS-1:0] cur_val;
   logic [15:0]             cur16;
   logic [15:0]             wr16;
   logic [COUNTER_BITS-1:0] wr_val;
   logic [7:0]              rd_data;
   logic                    wrap;
   logic [mpwm_pkg::LEVEL_BITS-1:0] levels;

   assign op        = head.op;
   assign load      = head.valid && (!out_valid_ff || rsp_pop);
   assign pop       = load;
   assign rsp_empty = !out_valid_ff;
   assign rsp_payload = out_ff;

   assign sel     = op.channel[CH_W-1:0];
   assign cur_val = op.sel_off ? off_ff[sel] : on_ff[sel];
   assign cur16   = 16'(cur_val);
   assign wr16    = op.sel_high ? {op.data, cur16[7:0]} : {cur16[15:8], op.data};
   assign wr_val  = COUNTER_BITS'(wr16);

   always_comb begin
      mode_in     = mode_ff;
      prescale_in = prescale_ff;
      div_in      = div_ff;
      period_in   = period_ff;
      on_in       = on_ff;
      off_in      = off_ff;
      rd_data     = 8'd0;
      wrap        = 1'b0;
      if (load) begin
         case (op.kind)
            mpwm_pkg::OP_TICK: begin
               if (!mode_ff[mpwm_pkg::BIT_SLEEP]) begin
                  if (div_ff >= prescale_ff) begin
                     div_in    = 8'd0;
                     period_in = period_ff + 1'b1;
                     wrap      = &period_ff;
                  end else begin
                     div_in = div_ff + 8'd1;
                  end
               end
            end
            mpwm_pkg::OP_WR_MODE: begin
               if (op.data[mpwm_pkg::BIT_RESTART]) begin
                  div_in    = 8'd0;
                  period_in = '0;
               end
               mode_in = op.data;
               mode_in[mpwm_pkg::BIT_RESTART] = 1'b0;
            end
            mpwm_pkg::OP_WR_PRESCALE: begin
               if (mode_ff[mpwm_pkg::BIT_SLEEP]) begin
                  prescale_in = (op.data < mpwm_pkg::PRESCALE_MIN) ?
                                mpwm_pkg::PRESCALE_MIN : op.data;
               end
            end
            mpwm_pkg::OP_WR_CHAN: begin
               if (op.sel_off) begin
                  off_in[sel] = wr_val;
               end else begin
                  on_in[sel] = wr_val;
               end
            end
            mpwm_pkg::OP_RD_MODE: begin
               rd_data = mode_ff;
            end
            mpwm_pkg::OP_RD_PRESCALE: begin
               rd_data = prescale_ff;
            end
            mpwm_pkg::OP_RD_CHAN: begin
               rd_data = op.sel_high ? cur16[15:8] : cur16[7:0];
            end
            default: begin
               rd_data = 8'd0;
            end
         endcase
      end
   end

   always_comb begin
      levels = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         if (on_in[c] < off_in[c]) begin
            levels[c] = (period_in >= on_in[c]) && (period_in < off_in[c]);
         end else if (on_in[c] > off_in[c]) begin
            levels[c] = (period_in >= on_in[c]) || (period_in < off_in[c]);
         end
      end
   end

   always_comb begin
      out_valid_in = load || (out_valid_ff && !rsp_pop);
      out_in       = out_ff;
      if (load) begin
         out_in.read_data   = rd_data;
         out_in.pwm_levels  = levels;
         out_in.period_wrap = wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mpwm_pkg::MODE_RESET;
         prescale_ff  <= mpwm_pkg::PRESCALE_RESET;
         div_ff       <= 8'd0;
         period_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            on_ff[c]  <= '0;
            off_ff[c] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         prescale_ff  <= prescale_in;
         div_ff       <= div_in;
         period_ff    <= period_in;
         out_valid_ff <= out_valid_in;
         on_ff        <= on_in;
         off_ff       <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      load && wrap |=> (period_ff == '0) && (div_ff == 8'd0))
      else $error("period wrap without counter returning to zero");
   assert property (@(posedge clock) disable iff (reset)
      prescale_ff >= mpwm_pkg::PRESCALE_MIN)
      else $error("prescale below minimum");
   assert property (@(posedge clock) disable iff (reset)
      !mode_ff[mpwm_pkg::BIT_RESTART])
      else $error("restart bit stored in mode byte");
   assert property (@(posedge clock) disable iff (reset)
      load && (op.kind != mpwm_pkg::OP_TICK) |-> !wrap)
      else $error("wrap flagged on a non-tick transfer");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_ff))
      else $error("pending result lost or changed");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the multichannel PWM register block.
module tb;
   import mpwm_pkg::*;

   localparam int CHANNEL_COUNT = 16;
   localparam int COUNTER_BITS  = 12;
   localparam int HIGH_BITS     = COUNTER_BITS - 8;
   localparam int RANDOM_ITEMS  = 1150;
   localparam int STALL_LIMIT   = 1000;
   localparam int WINDOW_TICKS  = 4 * 16;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int OFS_ON_LOW   = 0;
   localparam int OFS_ON_HIGH  = 1;
   localparam int OFS_OFF_LOW  = 2;
   localparam int OFS_OFF_HIGH = 3;

   localparam logic [7:0] ADDR_BELOW_CHANNELS = ADDR_CH_BASE - 8'd1;
   localparam logic [7:0] ADDR_PAST_CHANNELS  = ADDR_CH_BASE + 8'(4 * CHANNEL_COUNT);
   localparam logic [7:0] ADDR_TOP            = 8'hFF;

   localparam logic [7:0] MODE_RESTART = 8'(1 << BIT_RESTART);
   localparam logic [7:0] MODE_SLEEP   = 8'(1 << BIT_SLEEP);

   class pwm_scoreboard;
      logic [7:0]              mode_reg;
      logic [7:0]              prescale_reg;
      logic [7:0]              divider;
      logic [COUNTER_BITS-1:0] period;
      logic [COUNTER_BITS-1:0] on_time[CHANNEL_COUNT];
      logic [COUNTER_BITS-1:0] off_time[CHANNEL_COUNT];
      rsp_type                 awaited[$];
      int                      error_count;

      function new();
         mode_reg     = MODE_RESET;
         prescale_reg = PRESCALE_RESET;
         divider      = '0;
         period       = '0;
         error_count  = 0;
         foreach (on_time[c]) begin
            on_time[c]  = '0;
            off_time[c] = '0;
         end
      endfunction

      function logic [LEVEL_BITS-1:0] channel_levels();
         logic [LEVEL_BITS-1:0] lv;
         lv = '0;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (on_time[c] < off_time[c]) begin
               lv[c] = (period >= on_time[c]) && (period < off_time[c]);
            end else if (on_time[c] > off_time[c]) begin
               lv[c] = (period >= on_time[c]) || (period < off_time[c]);
            end
         end
         return lv;
      endfunction

      function rsp_type apply_request(req_type r);
         rsp_type                 rsp;
         int                      rel;
         int                      ch;
         logic                    mapped;
         logic [COUNTER_BITS-1:0] cur;
         rsp    = '0;
         cur    = '0;
         rel    = int'(r.reg_addr) - int'(ADDR_CH_BASE);
         ch     = rel / 4;
         mapped = (rel >= 0) && (ch < CHANNEL_COUNT);
         if (mapped) begin
            cur = rel[1] ? off_time[ch] : on_time[ch];
         end
         case (r.cmd)
            CMD_TICK: begin
               if (!mode_reg[BIT_SLEEP]) begin
                  if (divider >= prescale_reg) begin
                     divider = '0;
                     period  = period + 1'b1;
                     if (period == '0) rsp.period_wrap = 1'b1;
                  end else begin
                     divider = divider + 8'd1;
                  end
               end
            end
            CMD_WRITE: begin
               if (r.reg_addr == ADDR_MODE) begin
                  if (r.write_data[BIT_RESTART]) begin
                     divider = '0;
                     period  = '0;
                  end
                  mode_reg              = r.write_data;
                  mode_reg[BIT_RESTART] = 1'b0;
               end else if (r.reg_addr == ADDR_PRESCALE) begin
                  if (mode_reg[BIT_SLEEP]) begin
                     prescale_reg = (r.write_data < PRESCALE_MIN) ? PRESCALE_MIN : r.write_data;
                  end
               end else if (mapped) begin
                  if (rel[0]) cur = {r.write_data[HIGH_BITS-1:0], cur[7:0]};
                  else        cur = {cur[COUNTER_BITS-1:8], r.write_data};
                  if (rel[1]) off_time[ch] = cur;
                  else        on_time[ch]  = cur;
               end
            end
            CMD_READ: begin
               if (r.reg_addr == ADDR_MODE) begin
                  rsp.read_data = mode_reg;
               end else if (r.reg_addr == ADDR_PRESCALE) begin
                  rsp.read_data = prescale_reg;
               end else if (mapped) begin
                  rsp.read_data = rel[0] ? 8'(cur >> 8) : cur[7:0];
               end
            end
            default: ;
         endcase
         rsp.pwm_levels = channel_levels();
         return rsp;
      endfunction

      function void note_request(req_type r);
         awaited.push_back(apply_request(r));
      endfunction

      function int awaiting();
         return awaited.size();
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         error_count++;
         if (error_count <= 100) begin
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
         end
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report("response with nothing awaited", 32'(got), 32'd0);
            return;
         end
         want = awaited.pop_front();
         if (got.read_data !== want.read_data)
            report("read_data", 32'(got.read_data), 32'(want.read_data));
         if (got.pwm_levels !== want.pwm_levels)
            report("pwm_levels", 32'(got.pwm_levels), 32'(want.pwm_levels));
         if (got.period_wrap !== want.period_wrap)
            report("period_wrap", 32'(got.period_wrap), 32'(want.period_wrap));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_payload;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_payload;

   pwm_scoreboard board;
   int            req_gap_limit;
   int            rsp_gap_limit;
   int            stall_cycles;

   multichannel_pwm_register_block #(
      .CHANNEL_COUNT(CHANNEL_COUNT),
      .COUNTER_BITS (COUNTER_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_payload(req_payload),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [7:0] chan_addr(int ch, int ofs);
      return 8'(int'(ADDR_CH_BASE) + 4 * ch + ofs);
   endfunction

   task automatic put_request(input logic [1:0] cmd, input logic [7:0] addr,
                              input logic [7:0] data);
      int      gap;
      req_type r;
      gap          = $urandom_range(0, req_gap_limit);
      r.cmd        = cmd;
      r.reg_addr   = addr;
      r.write_data = data;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_random_item();
      int         pick;
      int         ch;
      int         ofs;
      logic [7:0] data;
      pick = $urandom_range(0, 99);
      ch   = $urandom_range(0, CHANNEL_COUNT - 1);
      ofs  = $urandom_range(OFS_ON_LOW, OFS_OFF_HIGH);
      data = 8'($urandom);
      if (pick < 40) begin
         put_request(CMD_TICK, 8'($urandom), data);
      end else if (pick < 65) begin
         if ((ofs == OFS_ON_HIGH || ofs == OFS_OFF_HIGH) && $urandom_range(0, 2) != 0)
            data = 8'h00;
         put_request(CMD_WRITE, chan_addr(ch, ofs), data);
      end else if (pick < 80) begin
         case ($urandom_range(0, 9))
            0, 1:    put_request(CMD_READ, ADDR_MODE, data);
            2, 3:    put_request(CMD_READ, ADDR_PRESCALE, data);
            4:       put_request(CMD_READ, 8'($urandom), data);
            default: put_request(CMD_READ, chan_addr(ch, ofs), data);
         endcase
      end else if (pick < 87) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: data = data & ~MODE_SLEEP;
            5, 6:          data = MODE_RESTART;
            default:       data = data | MODE_SLEEP;
         endcase
         put_request(CMD_WRITE, ADDR_MODE, data);
      end else if (pick < 94) begin
         if ($urandom_range(0, 4) != 0) data = 8'($urandom_range(0, 6));
         put_request(CMD_WRITE, ADDR_PRESCALE, data);
      end else begin
         put_request(2'($urandom_range(0, 3)), 8'($urandom), data);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("multichannel_pwm_register_block verification failed");
      $finish;
   end

   initial begin
      int gap;
      rsp_pop <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_limit);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty !== 1'b0) @(posedge clock);
         board.check_response(rsp_payload);
      end
   end

   initial begin
      board         = new();
      req_gap_limit = 6;
      rsp_gap_limit = 6;
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      put_request(CMD_READ,  ADDR_MODE, 8'h00);
      put_request(CMD_READ,  ADDR_PRESCALE, 8'h00);
      put_request(CMD_WRITE, ADDR_PRESCALE, 8'h00);
      put_request(CMD_READ,  ADDR_PRESCALE, 8'h00);
      put_request(CMD_WRITE, ADDR_PRESCALE, 8'hFF);
      put_request(CMD_READ,  ADDR_PRESCALE, 8'h00);
      put_request(CMD_WRITE, chan_addr(0, OFS_ON_LOW), 8'hFF);
      put_request(CMD_WRITE, chan_addr(0, OFS_ON_HIGH), 8'hFF);
      put_request(CMD_READ,  chan_addr(0, OFS_ON_HIGH), 8'h00);
      put_request(CMD_WRITE, chan_addr(CHANNEL_COUNT - 1, OFS_OFF_HIGH), 8'hA5);
      put_request(CMD_WRITE, chan_addr(CHANNEL_COUNT - 1, OFS_OFF_LOW), 8'h80);
      put_request(CMD_READ,  chan_addr(CHANNEL_COUNT - 1, OFS_OFF_LOW), 8'h00);
      put_request(CMD_WRITE, ADDR_PAST_CHANNELS, 8'h5A);
      put_request(CMD_READ,  ADDR_PAST_CHANNELS, 8'h00);
      put_request(CMD_READ,  ADDR_BELOW_CHANNELS, 8'h00);
      put_request(CMD_WRITE, ADDR_TOP, 8'hFF);
      put_request(CMD_READ,  ADDR_TOP, 8'hFF);
      put_request(CMD_UNUSED, ADDR_MODE, 8'hFF);
      put_request(CMD_WRITE, ADDR_PRESCALE, PRESCALE_MIN);
      put_request(CMD_WRITE, ADDR_MODE, 8'h6F);
      put_request(CMD_READ,  ADDR_MODE, 8'h00);
      put_request(CMD_WRITE, ADDR_PRESCALE, 8'h40);
      put_request(CMD_READ,  ADDR_PRESCALE, 8'h00);
      put_request(CMD_TICK,  8'h00, 8'h00);
      put_request(CMD_WRITE, ADDR_MODE, 8'hFF);
      put_request(CMD_TICK,  8'hFF, 8'hFF);
      put_request(CMD_READ,  ADDR_MODE, 8'h00);

      // step through the wrapping window on channel 2
      put_request(CMD_WRITE, ADDR_MODE, MODE_SLEEP);
      put_request(CMD_WRITE, ADDR_PRESCALE, 8'h00);
      put_request(CMD_WRITE, chan_addr(2, OFS_ON_LOW), 8'hFA);
      put_request(CMD_WRITE, chan_addr(2, OFS_ON_HIGH), 8'h0F);
      put_request(CMD_WRITE, chan_addr(2, OFS_OFF_LOW), 8'h05);
      put_request(CMD_WRITE, chan_addr(2, OFS_OFF_HIGH), 8'h00);
      put_request(CMD_WRITE, ADDR_MODE, MODE_RESTART);
      req_gap_limit = 0;
      rsp_gap_limit = 0;
      repeat (WINDOW_TICKS) put_request(CMD_TICK, 8'h00, 8'h00);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 3))
               0: begin req_gap_limit = 0; rsp_gap_limit = 0; end
               1: begin req_gap_limit = 0; rsp_gap_limit = 6; end
               2: begin req_gap_limit = 6; rsp_gap_limit = 0; end
               default: begin req_gap_limit = 6; rsp_gap_limit = 6; end
            endcase
         end
         send_random_item();
      end
      req_push <= 1'b0;

      while (board.awaiting() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.error_count == 0) begin
         $display("multichannel_pwm_register_block verification clean");
      end else begin
         $display("multichannel_pwm_register_block verification failed");
      end
      $finish;
   end

endmodule
